// ===== src/alle_pkg.sv =====
// ----------------------------------------------------------------------------
// Linked list engine package
// Shared sizes, command and status codes and the structs that pass between
// the sequencer, the slot store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

package alle_pkg;

    // Number of slots in the list store.
    localparam int DEPTH    = 16;
    // Bits of a slot index, and of a link that can also hold the null marker.
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int LINK_W   = $clog2(DEPTH + 1);
    // Counters that must reach DEPTH itself.
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // Field widths of the stream items.
    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 5;

    localparam int IN_FIELDS_W  = FUNC_W + 2 * DATA_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((STATUS_W + DATA_W + USED_W + 7) / 8) * 8;

    // The null link: one past the last slot.
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(DEPTH);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 3'd0,
        FUNC_INSERT = 3'd1,
        FUNC_DELETE = 3'd2,
        FUNC_SEARCH = 3'd3,
        FUNC_DUMP   = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_APPENDED  = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // One accepted command item.
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    // One result item.
    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] item_value;
        logic [USED_W-1:0]        used_count;
        logic                     last;
    } result_t;

    // Access request from the sequencer to the slot store.
    typedef struct packed {
        logic                     rd_en;
        logic [IDX_W-1:0]         rd_addr;
        logic                     we_val;
        logic                     we_link;
        logic [IDX_W-1:0]         wr_addr;
        logic signed [DATA_W-1:0] wr_val;
        logic [LINK_W-1:0]        wr_link;
    } store_req_t;

    // Registered read data of the slot store.
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic [LINK_W-1:0]        link;
    } store_rsp_t;

endpackage

`default_nettype wire

// ===== src/alle_store.sv =====
// ----------------------------------------------------------------------------
// Slot store
// Value and link memories of the list, one write and one registered read a
// cycle each. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module alle_store (
    input  wire                  clk,
    input  alle_pkg::store_req_t req,
    output alle_pkg::store_rsp_t rsp
);
    import alle_pkg::*;

    logic signed [DATA_W-1:0] val_mem [DEPTH];
    logic [LINK_W-1:0]        link_mem [DEPTH];
    store_rsp_t               rsp_reg;

    // Writes; value and link may be written at the same slot together.
    always_ff @(posedge clk)
    begin
        if (req.we_val)
        begin
            val_mem[req.wr_addr] <= req.wr_val;
        end
        if (req.we_link)
        begin
            link_mem[req.wr_addr] <= req.wr_link;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rsp_reg.val  <= val_mem[req.rd_addr];
            rsp_reg.link <= link_mem[req.rd_addr];
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== src/alle_out.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one result item for the output stream so that the sequencer can go
// on while the item waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module alle_out (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   push,
    input  alle_pkg::result_t                     res,
    output logic                                  free,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // status [2:0], item_value [34:3], used_count [39:35]
    output logic [alle_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast
);
    import alle_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // The register can take a new item when empty or being emptied now.
    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({res_reg.used_count, res_reg.item_value,
                                         res_reg.status});
    assign m_axis_tlast  = res_reg.last;

endmodule

`default_nettype wire

// ===== src/alle_ctrl.sv =====
// ----------------------------------------------------------------------------
// List sequencer
// Decodes a command, walks the list through the slot store one link at a
// time and writes back links, values, valid bits, head and count.
// ----------------------------------------------------------------------------
`default_nettype none

module alle_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  alle_pkg::cmd_t        in_cmd,
    input  wire                   out_free,
    output logic                  push,
    output alle_pkg::result_t     res,
    output alle_pkg::store_req_t  req,
    input  alle_pkg::store_rsp_t  rsp
);
    import alle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_CMP,
        S_LINK_FIX,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_REPLY
    } state_t;

    state_t                   state_reg,  state_next;
    logic [LINK_W-1:0]        head_reg,   head_next;
    logic [CNT_W-1:0]         count_reg,  count_next;
    logic [DEPTH-1:0]         used_reg,   used_next;
    logic [LINK_W-1:0]        cur_reg,    cur_next;
    logic [LINK_W-1:0]        prv_reg,    prv_next;
    logic [CNT_W-1:0]         steps_reg,  steps_next;
    logic [IDX_W-1:0]         slot_reg,   slot_next;
    logic [FUNC_W-1:0]        func_reg,   func_next;
    logic signed [DATA_W-1:0] key_reg,    key_next;
    logic signed [DATA_W-1:0] value_reg,  value_next;
    status_t                  status_reg, status_next;

    logic [IDX_W-1:0]         free_idx;
    logic                     full;
    logic [LINK_W-1:0]        rd_link;
    logic                     hit;

    // Lowest free slot.
    always_comb
    begin
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign full     = &used_reg;
    // A link beyond the store counts as the end of the list.
    assign rd_link  = (rsp.link >= NULL_LINK) ? NULL_LINK : rsp.link;
    assign hit      = used_reg[cur_reg[IDX_W-1:0]] && (rsp.val == key_reg);
    assign in_ready = (state_reg == S_IDLE);

    // Next-state and store access logic.
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        used_next   = used_reg;
        cur_next    = cur_reg;
        prv_next    = prv_reg;
        steps_next  = steps_reg;
        slot_next   = slot_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        value_next  = value_reg;
        status_next = status_reg;
        req         = '0;
        push        = 1'b0;
        res         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = in_cmd.func;
                    key_next    = in_cmd.key;
                    value_next  = in_cmd.value;
                    slot_next   = free_idx;
                    cur_next    = head_reg;
                    prv_next    = NULL_LINK;
                    steps_next  = '0;
                    status_next = ST_OK;
                    state_next  = S_REPLY;
                    unique case (in_cmd.func) inside
                        FUNC_ADD:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                req.we_val          = 1'b1;
                                req.we_link         = 1'b1;
                                req.wr_addr         = free_idx;
                                req.wr_val          = in_cmd.value;
                                req.wr_link         = head_reg;
                                head_next           = LINK_W'(free_idx);
                                used_next[free_idx] = 1'b1;
                                count_next          = count_reg + 1'b1;
                            end
                        end
                        FUNC_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_WALK_RD;
                            end
                        end
                        FUNC_DELETE, FUNC_SEARCH:
                        begin
                            state_next = S_WALK_RD;
                        end
                        FUNC_DUMP:
                        begin
                            if (head_reg == NULL_LINK)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            // Issue the read of the current node, or finish at the end of the list or after DEPTH steps.
            S_WALK_RD:
            begin
                if (cur_reg == NULL_LINK || steps_reg == CNT_W'(DEPTH))
                begin
                    state_next = S_REPLY;
                    if (func_reg == FUNC_INSERT)
                    begin
                        // Key absent: append at the tail.
                        req.we_val          = 1'b1;
                        req.we_link         = 1'b1;
                        req.wr_addr         = slot_reg;
                        req.wr_val          = value_reg;
                        req.wr_link         = NULL_LINK;
                        used_next[slot_reg] = 1'b1;
                        count_next          = count_reg + 1'b1;
                        status_next         = ST_APPENDED;
                        if (prv_reg == NULL_LINK)
                        begin
                            head_next = LINK_W'(slot_reg);
                        end
                        else
                        begin
                            state_next = S_LINK_FIX;
                        end
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = cur_reg[IDX_W-1:0];
                    state_next  = S_WALK_CMP;
                end
            end

            // Compare the node read in the previous cycle with the key.
            S_WALK_CMP:
            begin
                if (hit)
                begin
                    state_next  = S_REPLY;
                    status_next = ST_OK;
                    if (func_reg == FUNC_INSERT)
                    begin
                        req.we_val          = 1'b1;
                        req.we_link         = 1'b1;
                        req.wr_addr         = slot_reg;
                        req.wr_val          = value_reg;
                        req.wr_link         = cur_reg;
                        used_next[slot_reg] = 1'b1;
                        count_next          = count_reg + 1'b1;
                        if (prv_reg == NULL_LINK)
                        begin
                            head_next = LINK_W'(slot_reg);
                        end
                        else
                        begin
                            state_next = S_LINK_FIX;
                        end
                    end
                    else if (func_reg == FUNC_DELETE)
                    begin
                        // Unlink the match and free its slot.
                        if (prv_reg == NULL_LINK)
                        begin
                            head_next = rd_link;
                        end
                        else
                        begin
                            req.we_link = 1'b1;
                            req.wr_addr = prv_reg[IDX_W-1:0];
                            req.wr_link = rd_link;
                        end
                        used_next[cur_reg[IDX_W-1:0]] = 1'b0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                else
                begin
                    prv_next   = cur_reg;
                    cur_next   = rd_link;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WALK_RD;
                end
            end

            // Point the predecessor at the new node.
            S_LINK_FIX:
            begin
                req.we_link = 1'b1;
                req.wr_addr = prv_reg[IDX_W-1:0];
                req.wr_link = LINK_W'(slot_reg);
                state_next  = S_REPLY;
            end

            S_DUMP_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = cur_reg[IDX_W-1:0];
                state_next  = S_DUMP_OUT;
            end

            // One result per node; the last one closes the command.
            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    push           = 1'b1;
                    res.status     = ST_OK;
                    res.item_value = rsp.val;
                    res.used_count = USED_W'(count_reg);
                    res.last       = (rd_link == NULL_LINK) ||
                                     (steps_reg == CNT_W'(DEPTH - 1));
                    if (res.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = rd_link;
                        steps_next = steps_reg + 1'b1;
                        state_next = S_DUMP_RD;
                    end
                end
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    push           = 1'b1;
                    res.status     = status_reg;
                    res.item_value = '0;
                    res.used_count = USED_W'(count_reg);
                    res.last       = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= NULL_LINK;
            count_reg  <= '0;
            used_reg   <= '0;
            cur_reg    <= NULL_LINK;
            prv_reg    <= NULL_LINK;
            steps_reg  <= '0;
            status_reg <= ST_OK;
            func_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            used_reg   <= used_next;
            cur_reg    <= cur_next;
            prv_reg    <= prv_next;
            steps_reg  <= steps_next;
            status_reg <= status_next;
            func_reg   <= func_next;
        end
    end

    // Command payload needs no reset.
    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    // The count always matches the number of occupied slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(used_reg)))
        else $error("used count differs from occupied slots");

    // The list is empty exactly when no slot is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NULL_LINK) == (count_reg == '0))
        else $error("head and count disagree on an empty list");

    // Read data is first used in the cycle after the read; a dump result
    // waiting for the output keeps the data of that read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_CMP ||
         (state_reg == S_DUMP_OUT && $past(state_reg) != S_DUMP_OUT)) |->
        $past(req.rd_en))
        else $error("store data used without a read");

    // A result is only handed over when the result register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed into a full register");

    // A new node is only placed in a free slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.we_val && state_reg != S_IDLE) |-> !used_reg[req.wr_addr])
        else $error("new node written over an occupied slot");

endmodule

`default_nettype wire

// ===== src/array_linked_list_engine_top.sv =====
// Add, full and unknown commands and a dump of an empty list go from the accepted item
// straight to the reply state. Insert, delete and search walk the slot store one link
// at a time, a read and a compare state per link, as its single read port is registered.
// Dump reads each node and gives one result per node, with tlast on the final one.
// One command is worked at a time; the result register lets the next item in meanwhile.
// Reset leaves an empty list: head null, count zero, all valid bits clear, no sweep.
// ----------------------------------------------------------------------------
// Array linked list engine
// Singly linked list of signed values kept in a slot array, with add,
// insert before key, delete, search and dump commands.
// ----------------------------------------------------------------------------
`default_nettype none

module array_linked_list_engine_top (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // func [2:0], key [34:3], value [66:35], zero pad above
    input  wire  [alle_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // status [2:0], item_value [34:3], used_count [39:35]
    output logic [alle_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast
);
    import alle_pkg::*;

    cmd_t       cmd;
    result_t    res;
    store_req_t req;
    store_rsp_t rsp;
    logic       push;
    logic       out_free;

    // Unpack the command item.
    assign cmd.func  = s_axis_tdata[FUNC_W-1:0];
    assign cmd.key   = s_axis_tdata[FUNC_W +: DATA_W];
    assign cmd.value = s_axis_tdata[FUNC_W + DATA_W +: DATA_W];

    alle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (cmd),
        .out_free (out_free),
        .push     (push),
        .res      (res),
        .req      (req),
        .rsp      (rsp)
    );

    alle_store u_store (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    alle_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .res           (res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== test/array_linked_list_engine_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Array linked list engine testbench
// Sends add, insert, delete, search, dump and unknown commands over the
// input stream, keeps a mirror of the slot array that predicts every reply,
// and compares each reply item field by field, with random idling on both
// sides of the block.
// ----------------------------------------------------------------------------

module array_linked_list_engine_top_tb;

    import alle_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SEGMENT_ITEMS   = 18;
    localparam int SEGMENTS        = 5;

    // Mirror of the list: predicts the replies of each accepted command and
    // holds them until the block sends them.
    class list_mirror;
        logic signed [DATA_W-1:0] slot_val [DEPTH];
        int                       slot_nxt [DEPTH];
        bit                       slot_busy [DEPTH];
        int                       head;
        int                       count;
        result_t                  due_replies [$];
        int                       errors;

        function new();
            head   = DEPTH;
            count  = 0;
            errors = 0;
            foreach (slot_busy[i])
            begin
                slot_busy[i] = 1'b0;
                slot_nxt[i]  = DEPTH;
                slot_val[i]  = '0;
            end
        endfunction

        // A link that points outside the array counts as the null link.
        function int link_of(int idx);
            if (idx >= DEPTH)
                return DEPTH;
            return (slot_nxt[idx] >= DEPTH) ? DEPTH : slot_nxt[idx];
        endfunction

        // Walks the list for the first node holding k; prv ends on the
        // predecessor of the match, or on the tail when there is none.
        function bit locate(logic signed [DATA_W-1:0] k, output int cur, output int prv);
            int c;
            int p;
            int steps;
            c = head;
            p = DEPTH;
            steps = 0;
            while (c < DEPTH && steps < DEPTH)
            begin
                if (slot_busy[c] && slot_val[c] == k)
                begin
                    cur = c;
                    prv = p;
                    return 1'b1;
                end
                p = c;
                c = link_of(c);
                steps++;
            end
            cur = DEPTH;
            prv = p;
            return 1'b0;
        endfunction

        function void due(status_t st, logic signed [DATA_W-1:0] v, bit fin);
            result_t r;
            r.status     = st;
            r.item_value = v;
            r.used_count = USED_W'(count);
            r.last       = fin;
            due_replies.push_back(r);
        endfunction

        // Value of some stored node, so that keys mostly hit the list.
        function logic signed [DATA_W-1:0] any_stored_value();
            int busy [$];
            foreach (slot_busy[i])
                if (slot_busy[i])
                    busy.push_back(i);
            if (busy.size() == 0)
                return $urandom();
            return slot_val[busy[$urandom_range(0, busy.size() - 1)]];
        endfunction

        // Updates the mirror with one accepted command and queues its replies.
        function void apply_command(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] k,
                                    logic signed [DATA_W-1:0] v);
            int      slot;
            int      cur;
            int      prv;
            int      n;
            int      nx;
            bit      found;
            status_t st;
            case (f) inside
                FUNC_ADD, FUNC_INSERT:
                begin
                    slot = DEPTH;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!slot_busy[i])
                            slot = i;
                    if (count >= DEPTH || slot >= DEPTH)
                    begin
                        due(ST_FULL, '0, 1'b1);
                        return;
                    end
                    slot_val[slot] = v;
                    st = ST_OK;
                    if (f == FUNC_ADD)
                    begin
                        slot_nxt[slot] = head;
                        head = slot;
                    end
                    else
                    begin
                        found = locate(k, cur, prv);
                        slot_nxt[slot] = found ? cur : DEPTH;
                        if (prv >= DEPTH)
                            head = slot;
                        else
                            slot_nxt[prv] = slot;
                        if (!found)
                            st = ST_APPENDED;
                    end
                    slot_busy[slot] = 1'b1;
                    count++;
                    due(st, '0, 1'b1);
                end
                FUNC_DELETE:
                begin
                    found = locate(k, cur, prv);
                    if (found)
                    begin
                        if (prv >= DEPTH)
                            head = link_of(cur);
                        else
                            slot_nxt[prv] = link_of(cur);
                        slot_busy[cur] = 1'b0;
                        if (count > 0)
                            count--;
                    end
                    due(found ? ST_OK : ST_NOT_FOUND, '0, 1'b1);
                end
                FUNC_SEARCH:
                begin
                    found = locate(k, cur, prv);
                    due(found ? ST_OK : ST_NOT_FOUND, '0, 1'b1);
                end
                FUNC_DUMP:
                begin
                    if (head >= DEPTH)
                    begin
                        due(ST_EMPTY, '0, 1'b1);
                        return;
                    end
                    n = 0;
                    cur = head;
                    while (cur < DEPTH && n < DEPTH)
                    begin
                        nx = link_of(cur);
                        due(ST_OK, slot_val[cur], (nx >= DEPTH) || (n + 1 >= DEPTH));
                        n++;
                        cur = nx;
                    end
                end
                default:
                    due(ST_OK, '0, 1'b1);
            endcase
        endfunction

        task report(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] seen);
            $display("%0t ns: reply %s mismatch, expected %0h, got %0h",
                     $time, field, want, seen);
            errors++;
        endtask

        // Compares one accepted reply item with the oldest prediction.
        task check_reply(result_t got);
            result_t want;
            if (due_replies.size() == 0)
            begin
                report("without command", '0, got.item_value);
                return;
            end
            want = due_replies.pop_front();
            if (got.status !== want.status)
                report("status", want.status, got.status);
            if (got.item_value !== want.item_value)
                report("item_value", want.item_value, got.item_value);
            if (got.used_count !== want.used_count)
                report("used_count", want.used_count, got.used_count);
            if (got.last !== want.last)
                report("last", want.last, got.last);
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    list_mirror mirror = new();

    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int rx_wait = 0;
    int idle_cycles = 0;

    array_linked_list_engine_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Reply side: a random stall after each accepted item, none in burst phases.
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            n = rx_burst ? 0 : $urandom_range(0, 9);
            rx_wait       <= n;
            m_axis_tready <= (n == 0);
        end
        else if (rx_wait != 0)
        begin
            rx_wait       <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Reply checking.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status     = status_t'(m_axis_tdata[2:0]);
            got.item_value = m_axis_tdata[34:3];
            got.used_count = m_axis_tdata[39:35];
            got.last       = m_axis_tlast;
            mirror.check_reply(got);
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("array_linked_list_engine_top_tb failed");
                $finish;
            end
        end
    end

    // Sends one command item after a random gap; valid stays high when the
    // gap is zero, so it is never lowered and raised in one step.
    task automatic send_command(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] k,
                                logic signed [DATA_W-1:0] v);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({v, k, f});
        do
            @(posedge clk);
        while (!s_axis_tready);
        mirror.apply_command(f, k, v);
    endtask

    // Holds the sender back until every predicted reply has arrived.
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (mirror.due_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] any_word();
        case ($urandom_range(0, 9)) inside
            0, 1, 2: return $signed(DATA_W'($urandom_range(0, 4))) - 2;
            3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // One random command; a growing phase mostly stores, a shrinking one
    // mostly deletes, and keys mostly name values already in the list.
    task automatic random_command(bit growing);
        int                       pick;
        logic [FUNC_W-1:0]        f;
        logic signed [DATA_W-1:0] k;
        pick = $urandom_range(0, 99);
        if (growing)
            f = pick < 45 ? FUNC_ADD : pick < 84 ? FUNC_INSERT : pick < 89 ? FUNC_DELETE :
                pick < 95 ? FUNC_SEARCH : pick < 98 ? FUNC_DUMP :
                FUNC_W'($urandom_range(5, 7));
        else
            f = pick < 10 ? FUNC_ADD : pick < 20 ? FUNC_INSERT : pick < 78 ? FUNC_DELETE :
                pick < 90 ? FUNC_SEARCH : pick < 97 ? FUNC_DUMP :
                FUNC_W'($urandom_range(5, 7));
        k = ($urandom_range(0, 9) < 8) ? mirror.any_stored_value() : any_word();
        send_command(f, k, any_word());
    endtask

    // Stimulus.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Commands on the empty list.
        send_command(FUNC_DUMP, 0, 0);
        send_command(FUNC_SEARCH, 5, 0);
        send_command(FUNC_DELETE, 5, 0);
        send_command(FUNC_INSERT, 5, 32'h7FFF_FFFF);
        // Field extremes and inserts at the head, middle and tail.
        send_command(FUNC_ADD, 32'h8000_0000, 32'h8000_0000);
        send_command(FUNC_ADD, 0, -1);
        send_command(FUNC_INSERT, 32'h7FFF_FFFF, 0);
        send_command(FUNC_INSERT, -1, 1234);
        send_command(FUNC_INSERT, 42, 32'h5555_5555);
        send_command(FUNC_SEARCH, 32'h8000_0000, 0);
        send_command(FUNC_SEARCH, 99, 0);
        send_command(FUNC_DUMP, 0, 0);
        // Deletes of the head, the tail and a missing value.
        send_command(FUNC_DELETE, 1234, 0);
        send_command(FUNC_DELETE, 32'h5555_5555, 0);
        send_command(FUNC_DELETE, 77, 0);
        // Unknown commands leave the list alone.
        send_command(3'd5, -1, -1);
        send_command(3'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // A duplicate value: insert goes before the first match.
        send_command(FUNC_ADD, 0, 0);
        send_command(FUNC_INSERT, 0, 7);
        send_command(FUNC_DUMP, 0, 0);
        drain_replies();

        // Random phases, alternately filling and emptying the list.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            tx_burst = (seg == 1) || (seg == 2);
            rx_burst = (seg == 2) || (seg == 3);
            for (int i = 0; i < SEGMENT_ITEMS; i++)
                random_command(seg % 2 == 0);
            drain_replies();
        end

        repeat (2 * DEPTH + 8) @(posedge clk);
        if (mirror.errors == 0)
            $display("array_linked_list_engine_top_tb passed");
        else
            $display("array_linked_list_engine_top_tb failed");
        $finish;
    end

endmodule
